// ----- src/tabd_pkg.sv -----
// Shared types, constants and register map of the tensor backward-difference unit.
package tabd_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;

  localparam int DATA_W     = 32;
  localparam int INV_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int AXIS_W     = 2;
  localparam int CFG_SIZE_W = 6;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_AXIS_SELECT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INV_STEP_PLANE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INV_STEP_ROW  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INV_STEP_COL  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROWS_IN_USE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COLS_IN_USE   = 3'd5;

  localparam logic [AXIS_W-1:0]     AXIS_RST = 2'd0;
  localparam logic [INV_W-1:0]      INV_RST  = 32'h0001_0000;
  localparam logic [CFG_SIZE_W-1:0] SIZE_RST = 6'd32;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_PLANE = 2'd0,
    AXIS_ROW   = 2'd1,
    AXIS_COL   = 2'd2
  } axis_t;

  typedef struct packed {
    logic [AXIS_W-1:0]     axis;
    logic [INV_W-1:0]      inv_plane;
    logic [INV_W-1:0]      inv_row;
    logic [INV_W-1:0]      inv_col;
    logic [CFG_SIZE_W-1:0] rows;
    logic [CFG_SIZE_W-1:0] cols;
  } cfg_t;

  // Per-item control handed from the position tracker to the datapath
  typedef struct packed {
    logic             boundary;
    logic [INV_W-1:0] inv;
  } item_ctl_t;

endpackage

// ----- src/tabd_cfg.sv -----
// APB-style configuration registers.
module tabd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tabd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tabd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tabd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output tabd_pkg::cfg_t                   cfg
);

  tabd_pkg::cfg_t                  cfg_r;
  logic                            wr_en;
  logic [tabd_pkg::REG_IDX_W-1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[tabd_pkg::APB_ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis      <= tabd_pkg::AXIS_RST;
      cfg_r.inv_plane <= tabd_pkg::INV_RST;
      cfg_r.inv_row   <= tabd_pkg::INV_RST;
      cfg_r.inv_col   <= tabd_pkg::INV_RST;
      cfg_r.rows      <= tabd_pkg::SIZE_RST;
      cfg_r.cols      <= tabd_pkg::SIZE_RST;
    end else if (wr_en) begin
      unique case (idx)
        tabd_pkg::REG_AXIS_SELECT:    cfg_r.axis      <= pwdata[tabd_pkg::AXIS_W-1:0];
        tabd_pkg::REG_INV_STEP_PLANE: cfg_r.inv_plane <= pwdata[tabd_pkg::INV_W-1:0];
        tabd_pkg::REG_INV_STEP_ROW:   cfg_r.inv_row   <= pwdata[tabd_pkg::INV_W-1:0];
        tabd_pkg::REG_INV_STEP_COL:   cfg_r.inv_col   <= pwdata[tabd_pkg::INV_W-1:0];
        tabd_pkg::REG_ROWS_IN_USE:    cfg_r.rows      <= pwdata[tabd_pkg::CFG_SIZE_W-1:0];
        tabd_pkg::REG_COLS_IN_USE:    cfg_r.cols      <= pwdata[tabd_pkg::CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tabd_pkg::REG_AXIS_SELECT:    prdata = tabd_pkg::APB_DATA_W'(cfg_r.axis);
      tabd_pkg::REG_INV_STEP_PLANE: prdata = tabd_pkg::APB_DATA_W'(cfg_r.inv_plane);
      tabd_pkg::REG_INV_STEP_ROW:   prdata = tabd_pkg::APB_DATA_W'(cfg_r.inv_row);
      tabd_pkg::REG_INV_STEP_COL:   prdata = tabd_pkg::APB_DATA_W'(cfg_r.inv_col);
      tabd_pkg::REG_ROWS_IN_USE:    prdata = tabd_pkg::APB_DATA_W'(cfg_r.rows);
      tabd_pkg::REG_COLS_IN_USE:    prdata = tabd_pkg::APB_DATA_W'(cfg_r.cols);
      default:                      prdata = '0;
    endcase
  end

endmodule

// ----- src/tabd_seq.sv -----
// Raster position tracking and plane-buffer address generation.
module tabd_seq #(
  parameter int MAX_ROWS = tabd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tabd_pkg::MAX_COLS_DEF,
  parameter int ADDR_W   = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  tensor_start,
  input  tabd_pkg::cfg_t        cfg,
  output logic [ADDR_W-1:0]     wr_addr,
  output logic [ADDR_W-1:0]     rd_addr,
  output tabd_pkg::item_ctl_t   ctl
);

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int MAXD   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int SZ_RAW = $clog2(MAXD + 1);
  localparam int SZ_W   = (SZ_RAW > tabd_pkg::CFG_SIZE_W) ? SZ_RAW : tabd_pkg::CFG_SIZE_W;

  logic [ROW_W-1:0] row_pos_r, row_pos_nxt, r_cur;
  logic [COL_W-1:0] col_pos_r, col_pos_nxt, c_cur;
  logic             past_first_r, past_first_nxt, pfp_cur;
  logic [SZ_W-1:0]  rows_cfg, cols_cfg, rows_eff, cols_eff, row_inc, col_inc;
  logic [ADDR_W-1:0] here;

  // Size registers of zero act as one, oversize clamps to the buffer bound
  assign rows_cfg = SZ_W'(cfg.rows);
  assign cols_cfg = SZ_W'(cfg.cols);
  assign rows_eff = (rows_cfg == '0) ? SZ_W'(1) :
                    (rows_cfg > SZ_W'(MAX_ROWS)) ? SZ_W'(MAX_ROWS) : rows_cfg;
  assign cols_eff = (cols_cfg == '0) ? SZ_W'(1) :
                    (cols_cfg > SZ_W'(MAX_COLS)) ? SZ_W'(MAX_COLS) : cols_cfg;

  assign r_cur   = tensor_start ? '0   : row_pos_r;
  assign c_cur   = tensor_start ? '0   : col_pos_r;
  assign pfp_cur = tensor_start ? 1'b0 : past_first_r;

  assign here    = ADDR_W'(r_cur) * ADDR_W'(MAX_COLS) + ADDR_W'(c_cur);
  assign wr_addr = here;

  always_comb begin
    unique case (cfg.axis)
      tabd_pkg::AXIS_PLANE: begin
        ctl.boundary = !pfp_cur;
        ctl.inv      = cfg.inv_plane;
        rd_addr      = here;
      end
      tabd_pkg::AXIS_ROW: begin
        ctl.boundary = (r_cur == '0);
        ctl.inv      = cfg.inv_row;
        rd_addr      = here - ADDR_W'(MAX_COLS);
      end
      default: begin
        // column axis, also for the unused code
        ctl.boundary = (c_cur == '0);
        ctl.inv      = cfg.inv_col;
        rd_addr      = here - ADDR_W'(1);
      end
    endcase
  end

  assign row_inc = SZ_W'(r_cur) + SZ_W'(1);
  assign col_inc = SZ_W'(c_cur) + SZ_W'(1);

  always_comb begin
    row_pos_nxt    = r_cur;
    col_pos_nxt    = c_cur;
    past_first_nxt = pfp_cur;
    if (col_inc >= cols_eff) begin
      col_pos_nxt = '0;
      if (row_inc >= rows_eff) begin
        row_pos_nxt    = '0;
        past_first_nxt = 1'b1;
      end else begin
        row_pos_nxt = row_inc[ROW_W-1:0];
      end
    end else begin
      col_pos_nxt = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r    <= '0;
      col_pos_r    <= '0;
      past_first_r <= 1'b0;
    end else if (accept) begin
      row_pos_r    <= row_pos_nxt;
      col_pos_r    <= col_pos_nxt;
      past_first_r <= past_first_nxt;
    end
  end

endmodule

// ----- src/tabd_store.sv -----
// Plane buffer: one write port, one registered read port, read-before-write.
module tabd_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [tabd_pkg::DATA_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [tabd_pkg::DATA_W-1:0] rdata
);

  logic [tabd_pkg::DATA_W-1:0] mem [DEPTH];

  // Same-cycle read of the written entry returns the old contents
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ----- src/tabd_scale.sv -----
// Subtract, scale by reciprocal step, truncate and saturate, zero at boundaries; stalls per stage.
module tabd_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tabd_pkg::DATA_W-1:0] cur,
  input  tabd_pkg::item_ctl_t         ctl,
  input  logic [tabd_pkg::DATA_W-1:0] prev,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tabd_pkg::DATA_W-1:0] derivative,
  output logic                        on_boundary
);

  localparam int DW  = tabd_pkg::DATA_W;
  localparam int IW  = tabd_pkg::INV_W;
  localparam int FW  = tabd_pkg::FRAC_W;
  localparam int MW  = DW + 1;           // difference magnitude
  localparam int LW  = FW + IW;          // low partial product
  localparam int HW  = (MW - FW) + IW;   // high partial product
  localparam int QW  = HW + 1;

  logic            v1_r, v2_r, v3_r, vo_r;
  logic            ld1, ld2, ld3, ldo;

  logic [DW-1:0]   cur1_r;
  logic            bnd1_r;
  logic [IW-1:0]   inv1_r;

  logic [MW-1:0]   diff, mag;
  logic [MW-1:0]   mag2_r;
  logic            neg2_r, bnd2_r;
  logic [IW-1:0]   inv2_r;

  logic [LW-1:0]   p_lo;
  logic [HW-1:0]   p_hi;
  logic [LW-1:0]   plo3_r;
  logic [HW-1:0]   phi3_r;
  logic            neg3_r, bnd3_r;

  logic [QW-1:0]   q;
  logic [DW-1:0]   sat;
  logic [DW-1:0]   deriv_r;
  logic            bndo_r;

  assign ldo      = !vo_r || out_ready;
  assign ld3      = !v3_r || ldo;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  // stage 1: prev arrives from the buffer read register
  assign diff = {cur1_r[DW-1], cur1_r} - {prev[DW-1], prev};
  assign mag  = diff[MW-1] ? (~diff + MW'(1)) : diff;

  // stage 2: two partial products, the high one pre-aligned by the Q16 shift
  assign p_lo = LW'(mag2_r[FW-1:0]) * LW'(inv2_r);
  assign p_hi = HW'(mag2_r[MW-1:FW]) * HW'(inv2_r);

  // stage 3: recombine and saturate
  assign q = QW'(phi3_r) + QW'(plo3_r[LW-1:FW]);

  always_comb begin
    if (bnd3_r) begin
      sat = '0;
    end else if (neg3_r) begin
      if (q >= QW'({1'b1, {(DW-1){1'b0}}})) begin
        sat = {1'b1, {(DW-1){1'b0}}};
      end else begin
        sat = '0 - q[DW-1:0];
      end
    end else if (q > QW'({1'b0, {(DW-1){1'b1}}})) begin
      sat = {1'b0, {(DW-1){1'b1}}};
    end else begin
      sat = q[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ldo) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      cur1_r <= cur;
      bnd1_r <= ctl.boundary;
      inv1_r <= ctl.inv;
    end
    if (ld2) begin
      mag2_r <= mag;
      neg2_r <= diff[MW-1];
      bnd2_r <= bnd1_r;
      inv2_r <= inv1_r;
    end
    if (ld3) begin
      plo3_r <= p_lo;
      phi3_r <= p_hi;
      neg3_r <= neg2_r;
      bnd3_r <= bnd2_r;
    end
    if (ldo) begin
      deriv_r <= sat;
      bndo_r  <= bnd3_r;
    end
  end

  assign out_valid   = vo_r;
  assign derivative  = deriv_r;
  assign on_boundary = bndo_r;

endmodule

// ----- src/tensor_axis_backward_difference_unit.sv -----
// Top level: backward difference of a raster-streamed 3D tensor along one axis.
// Pipeline: buffer read, subtract, split multiply, recombine/saturate into the
// output register. Throughput: one item per cycle unless the output stalls; the
// plane buffer is written and read in the transfer cycle, so back-to-back items
// see their predecessor without forwarding.
// Reset clears registers, positions and pipeline valids; buffer contents are kept.
module tensor_axis_backward_difference_unit #(
  parameter int MAX_ROWS = tabd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tabd_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,   // [31:0] sample
  input  logic [0:0]                       in_tuser,   // [0] tensor_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,  // [31:0] derivative
  output logic [0:0]                       out_tuser,  // [0] on_boundary
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tabd_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [tabd_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [tabd_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tabd_pkg::cfg_t              cfg;
  tabd_pkg::item_ctl_t         ctl;
  logic                        accept;
  logic [ADDR_W-1:0]           wr_addr, rd_addr;
  logic [tabd_pkg::DATA_W-1:0] prev;

  assign accept = in_tvalid & in_tready;

  tabd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tabd_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .ADDR_W   (ADDR_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .tensor_start (in_tuser[0]),
    .cfg          (cfg),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr),
    .ctl          (ctl)
  );

  tabd_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_addr),
    .wdata (in_tdata),
    .re    (in_tready),
    .raddr (rd_addr),
    .rdata (prev)
  );

  tabd_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .cur         (in_tdata),
    .ctl         (ctl),
    .prev        (prev),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .derivative  (out_tdata),
    .on_boundary (out_tuser[0])
  );

  // Boundary results carry a zero derivative
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("boundary result with nonzero derivative");

  // Input is held off only when the pipeline is full behind a stalled output
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule
